// File: hdl/rgb_color_adjust_defines.svh
`ifndef RGB_COLOR_ADJUST_DEFINES_SVH
`define RGB_COLOR_ADJUST_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define RCA_ASSERT_IMPLY(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define RCA_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

// File: hdl/rca_pkg.sv
package rca_pkg;

    localparam int CH_BITS   = 8;
    localparam int NUM_CH    = 3;
    localparam int WORK_BITS = 2 * CH_BITS;
    localparam int MODE_BITS = 3;

    // Four divider stages with two quotient bits each give the eight quotient bits.
    localparam int DIV_STAGES      = 4;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DEPTH           = DIV_STAGES + 2;

    localparam logic [CH_BITS-1:0] CH_MAX      = '1;
    localparam logic [CH_BITS-1:0] PASTEL_BASE = 8'hCC;

    localparam logic [MODE_BITS-1:0] MODE_LIGHTEN   = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_DARKEN    = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_NORMALIZE = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_MIN_SCALE = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_PASTEL    = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_PURE      = 3'd5;
    localparam logic [MODE_BITS-1:0] MODE_INVERT    = 3'd6;
    localparam logic [MODE_BITS-1:0] MODE_PASS      = 3'd7;
    localparam logic [MODE_BITS-1:0] MODE_RESET     = MODE_PASS;

    typedef struct packed {
        logic [MODE_BITS-1:0]                mode;
        logic [NUM_CH-1:0][CH_BITS-1:0]      ch;
        logic [CH_BITS-1:0]                  dvs;
        logic                                zero;
        logic [1:0]                          first;
        logic [NUM_CH-1:0][WORK_BITS-1:0]    prod;
        logic [NUM_CH-1:0][WORK_BITS-1:0]    work;
    } pipe_t;

    // One restoring division step. The upper half of the word is the partial
    // remainder, the lower half holds the dividend bits still to come and
    // collects the quotient bits from the right.
    function automatic logic [WORK_BITS-1:0] div_step(input logic [WORK_BITS-1:0] w,
                                                      input logic [CH_BITS-1:0] d);
        logic [CH_BITS:0] x;
        logic [CH_BITS:0] diff;
        x    = {w[WORK_BITS-1:CH_BITS], w[CH_BITS-1]};
        diff = x - {1'b0, d};
        if (x >= {1'b0, d})
        begin
            div_step = {diff[CH_BITS-1:0], w[CH_BITS-2:0], 1'b1};
        end
        else
        begin
            div_step = {x[CH_BITS-1:0], w[CH_BITS-2:0], 1'b0};
        end
    endfunction

endpackage

// File: hdl/rca_in_if.sv
interface rca_in_if;
    logic                        valid;
    logic                        ready;
    logic [rca_pkg::CH_BITS-1:0] in_red;
    logic [rca_pkg::CH_BITS-1:0] in_green;
    logic [rca_pkg::CH_BITS-1:0] in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    input ready);
    modport sink (input valid, input in_red, input in_green, input in_blue,
                  output ready);
endinterface

// File: hdl/rca_out_if.sv
interface rca_out_if;
    logic                        valid;
    logic                        ready;
    logic [rca_pkg::CH_BITS-1:0] out_red;
    logic [rca_pkg::CH_BITS-1:0] out_green;
    logic [rca_pkg::CH_BITS-1:0] out_blue;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    input ready);
    modport sink (input valid, input out_red, input out_green, input out_blue,
                  output ready);
endinterface

// File: hdl/rca_front.sv
module rca_front (
    input  logic                          clk,
    input  logic                          rst_n,
    rca_in_if.sink                        pix_in,
    input  logic [rca_pkg::MODE_BITS-1:0] mode,
    input  logic                          ready_dn,
    output logic                          valid_dn,
    output rca_pkg::pipe_t                data_dn
);

    logic                                             valid_reg;
    rca_pkg::pipe_t                                   data_reg;
    rca_pkg::pipe_t                                   data_next;
    logic [rca_pkg::NUM_CH-1:0][rca_pkg::CH_BITS-1:0] c;
    logic [rca_pkg::CH_BITS-1:0]                      hi;
    logic [rca_pkg::CH_BITS-1:0]                      lo;

    assign c[0] = pix_in.in_red;
    assign c[1] = pix_in.in_green;
    assign c[2] = pix_in.in_blue;

    assign pix_in.ready = !valid_reg || ready_dn;

    always_comb
    begin
        hi = (c[0] > c[1]) ? c[0] : c[1];
        hi = (hi > c[2]) ? hi : c[2];
        lo = (c[0] < c[1]) ? c[0] : c[1];
        lo = (lo < c[2]) ? lo : c[2];

        data_next.mode = mode;
        data_next.ch   = c;
        data_next.dvs  = hi;
        data_next.zero = (hi == '0);
        priority if (c[0] == hi)
        begin
            data_next.first = 2'd0;
        end
        else if (c[1] == hi)
        begin
            data_next.first = 2'd1;
        end
        else
        begin
            data_next.first = 2'd2;
        end

        for (int i = 0; i < rca_pkg::NUM_CH; i++)
        begin
            data_next.prod[i] = {{rca_pkg::CH_BITS{1'b0}}, c[i]}
                              * {{rca_pkg::CH_BITS{1'b0}}, lo};
            // c * 255 as a shift and a subtract; it seeds the divider word.
            data_next.work[i] = {c[i], {rca_pkg::CH_BITS{1'b0}}}
                              - {{rca_pkg::CH_BITS{1'b0}}, c[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pix_in.ready)
        begin
            valid_reg <= pix_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_in.valid && pix_in.ready)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_dn = valid_reg;
    assign data_dn  = data_reg;

endmodule

// File: hdl/rca_div_stage.sv
module rca_div_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           valid_up,
    output logic           ready_up,
    input  rca_pkg::pipe_t data_up,
    output logic           valid_dn,
    input  logic           ready_dn,
    output rca_pkg::pipe_t data_dn
);

    logic           valid_reg;
    rca_pkg::pipe_t data_reg;
    rca_pkg::pipe_t data_next;

    assign ready_up = !valid_reg || ready_dn;

    always_comb
    begin
        data_next = data_up;
        for (int i = 0; i < rca_pkg::NUM_CH; i++)
        begin
            for (int s = 0; s < rca_pkg::STEPS_PER_STAGE; s++)
            begin
                data_next.work[i] = rca_pkg::div_step(data_next.work[i], data_up.dvs);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_up;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_up && ready_up)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_dn = valid_reg;
    assign data_dn  = data_reg;

endmodule

// File: hdl/rca_back.sv
module rca_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           valid_up,
    output logic           ready_up,
    input  rca_pkg::pipe_t data_up,
    rca_out_if.source      pix_out
);

    logic                                             valid_reg;
    logic [rca_pkg::NUM_CH-1:0][rca_pkg::CH_BITS-1:0] res_reg;
    logic [rca_pkg::NUM_CH-1:0][rca_pkg::CH_BITS-1:0] res_next;

    assign ready_up = !valid_reg || pix_out.ready;

    always_comb
    begin
        logic [rca_pkg::CH_BITS-1:0]   v;
        logic [rca_pkg::CH_BITS-1:0]   q;
        logic [rca_pkg::CH_BITS:0]     sum;
        logic [rca_pkg::WORK_BITS:0]   t;
        logic [rca_pkg::WORK_BITS:0]   u;
        sum = '0;
        t   = '0;
        u   = '0;
        for (int i = 0; i < rca_pkg::NUM_CH; i++)
        begin
            v = data_up.ch[i];
            q = data_up.work[i][rca_pkg::CH_BITS-1:0];
            unique case (data_up.mode)
                rca_pkg::MODE_LIGHTEN:
                begin
                    sum = {1'b0, v} + {2'b00, v[rca_pkg::CH_BITS-1:1]};
                    res_next[i] = sum[rca_pkg::CH_BITS] ? rca_pkg::CH_MAX
                                                        : sum[rca_pkg::CH_BITS-1:0];
                end
                rca_pkg::MODE_DARKEN:
                begin
                    res_next[i] = v - {1'b0, v[rca_pkg::CH_BITS-1:1]};
                end
                rca_pkg::MODE_NORMALIZE:
                begin
                    res_next[i] = data_up.zero ? '0 : q;
                end
                rca_pkg::MODE_MIN_SCALE:
                begin
                    // Exact floor division by 255 for products below 65535.
                    t = {1'b0, data_up.prod[i]} + 1'b1;
                    u = t + {{rca_pkg::CH_BITS{1'b0}}, t[rca_pkg::WORK_BITS:rca_pkg::CH_BITS]};
                    res_next[i] = u[rca_pkg::WORK_BITS-1:rca_pkg::CH_BITS];
                end
                rca_pkg::MODE_PASTEL:
                begin
                    sum = {1'b0, v} + {1'b0, rca_pkg::PASTEL_BASE};
                    res_next[i] = sum[rca_pkg::CH_BITS:1];
                end
                rca_pkg::MODE_PURE:
                begin
                    // Halving the quotient by max equals dividing by twice max.
                    if (data_up.zero)
                    begin
                        res_next[i] = '0;
                    end
                    else if (data_up.first == 2'(i))
                    begin
                        res_next[i] = rca_pkg::CH_MAX;
                    end
                    else
                    begin
                        res_next[i] = {1'b0, q[rca_pkg::CH_BITS-1:1]};
                    end
                end
                rca_pkg::MODE_INVERT:
                begin
                    res_next[i] = ~v;
                end
                rca_pkg::MODE_PASS:
                begin
                    res_next[i] = v;
                end
                default:
                begin
                    res_next[i] = v;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_up;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_up && ready_up)
        begin
            res_reg <= res_next;
        end
    end

    assign pix_out.valid     = valid_reg;
    assign pix_out.out_red   = res_reg[0];
    assign pix_out.out_green = res_reg[1];
    assign pix_out.out_blue  = res_reg[2];

endmodule

// File: hdl/rgb_color_adjust.sv
// Per-pixel color adjustment with a valid/ready pixel stream on each side.
// pix_in carries in_red, in_green and in_blue; pix_out carries out_red,
// out_green and out_blue. A transfer happens on a rising clk edge with valid
// and ready both high. cfg_we writes cfg_data into the mode register
// (lighten, darken, normalize, min scale, pastel, pure, invert, pass); write it
// only while no pixel is in flight.
// Each pixel passes six registered stages from its input transfer until its result
// is valid: an input stage (max, min, c*min and c*255), four divider stages of
// two restoring quotient bits each for c*255/max, and an output register.
// One pixel per clock is accepted and delivered when the receiver keeps ready
// high; every stage has its own valid bit and accepts while it is empty or
// moving on, so bubbles close up.
// When the receiver stalls, the output register holds its pixel and the
// stages behind it keep filling until all six hold a pixel; only then does
// pix_in.ready drop.
// rst_n clears every valid bit at once and sets the mode to pass-through.
module rgb_color_adjust (
    input  logic                          clk,
    input  logic                          rst_n,
    rca_in_if.sink                        pix_in,
    rca_out_if.source                     pix_out,
    input  logic                          cfg_we,
    input  logic [rca_pkg::MODE_BITS-1:0] cfg_data
);

    logic [rca_pkg::MODE_BITS-1:0] mode_reg;
    logic                          link_valid [rca_pkg::DIV_STAGES+1];
    logic                          link_ready [rca_pkg::DIV_STAGES+1];
    rca_pkg::pipe_t                link_data  [rca_pkg::DIV_STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= rca_pkg::MODE_RESET;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_data;
        end
    end

    rca_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_in   (pix_in),
        .mode     (mode_reg),
        .ready_dn (link_ready[0]),
        .valid_dn (link_valid[0]),
        .data_dn  (link_data[0])
    );

    for (genvar k = 0; k < rca_pkg::DIV_STAGES; k++)
    begin : g_div
        rca_div_stage u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .valid_up (link_valid[k]),
            .ready_up (link_ready[k]),
            .data_up  (link_data[k]),
            .valid_dn (link_valid[k+1]),
            .ready_dn (link_ready[k+1]),
            .data_dn  (link_data[k+1])
        );
    end

    rca_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_up (link_valid[rca_pkg::DIV_STAGES]),
        .ready_up (link_ready[rca_pkg::DIV_STAGES]),
        .data_up  (link_data[rca_pkg::DIV_STAGES]),
        .pix_out  (pix_out)
    );

endmodule

// File: hdl/rca_checker.sv
`include "rgb_color_adjust_defines.svh"

module rca_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [rca_pkg::CH_BITS-1:0] out_red,
    input logic [rca_pkg::CH_BITS-1:0] out_green,
    input logic [rca_pkg::CH_BITS-1:0] out_blue
);

    // Pixels accepted but not yet delivered; never more than the stage count.
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (in_xfer && !out_xfer)
        begin
            count_next = count_reg + 3'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    `RCA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                     out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue))
    `RCA_ASSERT_IMPLY(a_ready_flows_back, out_ready, in_ready)
    `RCA_ASSERT_IMPLY(a_no_overflow, 1'b1, count_reg <= 3'(rca_pkg::DEPTH))
    `RCA_ASSERT_IMPLY(a_no_invented, count_reg == 3'd0, !out_valid)

endmodule

bind rgb_color_adjust rca_checker u_rca_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .out_red   (pix_out.out_red),
    .out_green (pix_out.out_green),
    .out_blue  (pix_out.out_blue)
);

// File: tb/tb.sv
module tb;

    localparam int PIXEL_TARGET   = 1550;
    localparam int CALM_PIXELS    = 150;
    localparam int HOLD_MARK      = 500;
    localparam int HOLD_CYCLES    = 80;
    localparam int LATENCY        = 6;
    localparam int END_WAIT       = 4 * LATENCY;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [rca_pkg::CH_BITS-1:0] red;
        logic [rca_pkg::CH_BITS-1:0] green;
        logic [rca_pkg::CH_BITS-1:0] blue;
    } pixel_t;

    typedef enum logic {ITEM_PIXEL, ITEM_MODE} item_kind_t;

    typedef struct {
        item_kind_t                    kind;
        pixel_t                        pix;
        logic [rca_pkg::MODE_BITS-1:0] mode;
    } stim_item_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [rca_pkg::MODE_BITS-1:0] cfg_data;

    rca_in_if  pix_in_bus ();
    rca_out_if pix_out_bus ();

    rgb_color_adjust i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_in   (pix_in_bus),
        .pix_out  (pix_out_bus),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    stim_item_t                    stim_q[$];
    pixel_t                        expected_q[$];
    logic [rca_pkg::MODE_BITS-1:0] mode_setting;
    logic                          in_taken;
    int                            pixel_total;
    int                            pixels_offered;
    int                            pixels_accepted;
    int                            results_checked;
    int                            modes_written;
    int                            mismatches;
    int                            send_gap;
    int                            stall_left;
    int                            hold_left;
    int                            holds_done;
    int                            input_stall_cycles;
    int                            quiet_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Expected pixel for one input pixel under the given mode.
    function automatic pixel_t adjust_pixel(input logic [rca_pkg::MODE_BITS-1:0] mode_sel,
                                            input pixel_t px);
        int     chan[3];
        int     res[3];
        int     hi;
        int     lo;
        int     lead;
        int     v;
        int     top;
        pixel_t outp;
        top     = int'(rca_pkg::CH_MAX);
        chan[0] = px.red;
        chan[1] = px.green;
        chan[2] = px.blue;
        hi = chan[0];
        lo = chan[0];
        for (int k = 1; k < 3; k++)
        begin
            if (chan[k] > hi)
                hi = chan[k];
            if (chan[k] < lo)
                lo = chan[k];
        end
        // Ties go to the earliest channel in red, green, blue order.
        lead = (chan[0] == hi) ? 0 : ((chan[1] == hi) ? 1 : 2);
        for (int k = 0; k < 3; k++)
        begin
            v = chan[k];
            case (mode_sel)
                rca_pkg::MODE_LIGHTEN:
                begin
                    res[k] = v + v / 2;
                    if (res[k] > top)
                        res[k] = top;
                end
                rca_pkg::MODE_DARKEN:    res[k] = v - v / 2;
                rca_pkg::MODE_NORMALIZE: res[k] = (hi == 0) ? 0 : (v * top) / hi;
                rca_pkg::MODE_MIN_SCALE: res[k] = (v * lo) / top;
                rca_pkg::MODE_PASTEL:    res[k] = (v + int'(rca_pkg::PASTEL_BASE)) / 2;
                rca_pkg::MODE_PURE:
                begin
                    if (hi == 0)
                        res[k] = 0;
                    else if (k == lead)
                        res[k] = top;
                    else
                        res[k] = (v * top) / (2 * hi);
                end
                rca_pkg::MODE_INVERT:    res[k] = top - v;
                default:                 res[k] = v;
            endcase
        end
        outp.red   = res[0][rca_pkg::CH_BITS-1:0];
        outp.green = res[1][rca_pkg::CH_BITS-1:0];
        outp.blue  = res[2][rca_pkg::CH_BITS-1:0];
        return outp;
    endfunction

    // Input side: pixels and mode writes from the stimulus queue. A mode write
    // waits until every pixel already accepted has come out.
    always @(negedge clk)
    begin : drive_inputs
        logic                          next_valid;
        logic                          next_we;
        logic [rca_pkg::MODE_BITS-1:0] next_mode;
        pixel_t                        next_pix;
        stim_item_t                    head;
        next_valid = pix_in_bus.valid;
        next_we    = 1'b0;
        next_mode  = cfg_data;
        next_pix   = {pix_in_bus.in_red, pix_in_bus.in_green, pix_in_bus.in_blue};
        if (rst_n)
        begin
            if (pix_in_bus.valid && in_taken)
                next_valid = 1'b0;
            if (!next_valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (stim_q.size() > 0)
                begin
                    head = stim_q[0];
                    if (head.kind == ITEM_MODE)
                    begin
                        if (expected_q.size() == 0)
                        begin
                            next_we   = 1'b1;
                            next_mode = head.mode;
                            void'(stim_q.pop_front());
                            modes_written++;
                        end
                    end
                    else
                    begin
                        next_valid = 1'b1;
                        next_pix   = head.pix;
                        void'(stim_q.pop_front());
                        pixels_offered++;
                        if (pixels_offered < pixel_total - CALM_PIXELS && hold_left == 0
                            && $urandom_range(0, 7) == 0)
                            send_gap = $urandom_range(1, 12);
                    end
                end
            end
        end
        pix_in_bus.valid    <= next_valid;
        pix_in_bus.in_red   <= next_pix.red;
        pix_in_bus.in_green <= next_pix.green;
        pix_in_bus.in_blue  <= next_pix.blue;
        cfg_we              <= next_we;
        cfg_data            <= next_mode;
    end

    // Output side: random stall bursts, plus two long hold-offs that let the
    // pipeline fill and push back on the input.
    always @(negedge clk)
    begin : drive_ready
        if (!rst_n)
        begin
            pix_out_bus.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            pix_out_bus.ready <= 1'b0;
        end
        else if (holds_done < 2 && results_checked >= HOLD_MARK * (holds_done + 1))
        begin
            hold_left = HOLD_CYCLES - 1;
            holds_done++;
            pix_out_bus.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            pix_out_bus.ready <= 1'b0;
        end
        else if (results_checked < pixel_total - CALM_PIXELS && $urandom_range(0, 11) == 0)
        begin
            stall_left = $urandom_range(0, 11);
            pix_out_bus.ready <= 1'b0;
        end
        else
        begin
            pix_out_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : watch_ports
        pixel_t got;
        pixel_t want;
        logic   in_fire;
        logic   out_fire;
        in_fire  = rst_n && pix_in_bus.valid && pix_in_bus.ready;
        out_fire = rst_n && pix_out_bus.valid && pix_out_bus.ready;
        in_taken <= in_fire;
        if (!rst_n)
        begin
            mode_setting <= rca_pkg::MODE_RESET;
        end
        else
        begin
            if (cfg_we)
                mode_setting <= cfg_data;
            if (pix_in_bus.valid && !pix_in_bus.ready)
                input_stall_cycles++;
            if (in_fire)
            begin
                expected_q.push_back(adjust_pixel(mode_setting,
                    {pix_in_bus.in_red, pix_in_bus.in_green, pix_in_bus.in_blue}));
                pixels_accepted++;
            end
            if (out_fire)
            begin
                got = {pix_out_bus.out_red, pix_out_bus.out_green, pix_out_bus.out_blue};
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: unexpected pixel %02h %02h %02h",
                                 results_checked, got.red, got.green, got.blue);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.red != want.red || got.green != want.green
                        || got.blue != want.blue)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected %02h %02h %02h, got %02h %02h %02h",
                                     results_checked, want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                    end
                end
                results_checked++;
            end
            if (in_fire || out_fire || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", quiet_cycles);
                $display("tb failed");
                $finish;
            end
        end
    end

    initial
    begin : run
        logic [rca_pkg::MODE_BITS-1:0] mode_order[8];
        logic [23:0]                   corner_pixels[24];
        stim_item_t                    item;
        logic [23:0]                   bits;
        int                            burst;
        int                            a;
        int                            b;

        mode_order = '{rca_pkg::MODE_LIGHTEN, rca_pkg::MODE_DARKEN,
                       rca_pkg::MODE_NORMALIZE, rca_pkg::MODE_MIN_SCALE,
                       rca_pkg::MODE_PASTEL, rca_pkg::MODE_PURE,
                       rca_pkg::MODE_INVERT, rca_pkg::MODE_PASS};
        // Three pixels per mode: saturation of lighten, black for normalize and
        // pure, ties for the leading channel of pure, full-scale channels.
        corner_pixels = '{24'hFFABAA, 24'h000102, 24'h805554,
                          24'hFF0001, 24'hFE0380, 24'h64C84D,
                          24'h000000, 24'h010001, 24'h25C871,
                          24'hFFFFFF, 24'hFF01FE, 24'h0080FF,
                          24'h00FF33, 24'hCCCBCD, 24'h010101,
                          24'hC8C832, 24'h0A5A5A, 24'h000000,
                          24'hFF00AA, 24'h550FF0, 24'h323232,
                          24'hFF0080, 24'h01FE7F, 24'hAA55AA};

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_data             = rca_pkg::MODE_RESET;
        pix_in_bus.valid     = 1'b0;
        pix_in_bus.in_red    = '0;
        pix_in_bus.in_green  = '0;
        pix_in_bus.in_blue   = '0;
        pix_out_bus.ready    = 1'b0;
        mode_setting         = rca_pkg::MODE_RESET;
        in_taken             = 1'b0;
        pixel_total          = 0;
        pixels_offered       = 0;
        pixels_accepted      = 0;
        results_checked      = 0;
        modes_written        = 0;
        mismatches           = 0;
        send_gap             = 0;
        stall_left           = 0;
        hold_left            = 0;
        holds_done           = 0;
        input_stall_cycles   = 0;
        quiet_cycles         = 0;

        // A few pixels under the reset mode first.
        item.kind = ITEM_PIXEL;
        item.mode = rca_pkg::MODE_RESET;
        for (int j = 0; j < 2; j++)
        begin
            item.pix = pixel_t'(corner_pixels[21 + j]);
            stim_q.push_back(item);
            pixel_total++;
        end
        for (int m = 0; m < 8; m++)
        begin
            item.kind = ITEM_MODE;
            item.mode = mode_order[m];
            stim_q.push_back(item);
            item.kind = ITEM_PIXEL;
            for (int j = 0; j < 3; j++)
            begin
                item.pix = pixel_t'(corner_pixels[3 * m + j]);
                stim_q.push_back(item);
                pixel_total++;
            end
        end

        while (pixel_total < PIXEL_TARGET)
        begin
            item.kind = ITEM_MODE;
            item.mode = rca_pkg::MODE_BITS'($urandom_range(rca_pkg::MODE_LIGHTEN,
                                                           rca_pkg::MODE_PASS));
            stim_q.push_back(item);
            item.kind = ITEM_PIXEL;
            burst = $urandom_range(40, 160);
            if (burst > PIXEL_TARGET - pixel_total)
                burst = PIXEL_TARGET - pixel_total;
            repeat (burst)
            begin
                bits = 24'($urandom);
                case ($urandom_range(0, 7))
                    0: bits = {3{bits[7:0]}};
                    1:
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            case ($urandom_range(0, 2))
                                0:       bits[8*k +: 8] = '0;
                                1:       bits[8*k +: 8] = '1;
                                default: ;
                            endcase
                        end
                    end
                    2:
                    begin
                        // Two channels share a value, often the maximum.
                        a = $urandom_range(0, 2);
                        b = (a + 1 + $urandom_range(0, 1)) % 3;
                        bits[8*b +: 8] = bits[8*a +: 8];
                    end
                    default: ;
                endcase
                item.pix = pixel_t'(bits);
                stim_q.push_back(item);
                pixel_total++;
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (stim_q.size() != 0 || results_checked < pixel_total);
        repeat (END_WAIT) @(negedge clk);
        if (expected_q.size() != 0)
        begin
            mismatches += expected_q.size();
            $display("%0d expected pixels never came out", expected_q.size());
        end

        $display("Checked %0d pixels under %0d mode writes, covering every mode.",
                 results_checked, modes_written);
        $display("Receiver held off %0d times; input was stalled for %0d cycles.",
                 holds_done, input_stall_cycles);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
